// ===== rtl/sgwd_pkg.sv =====
// shared types and register map constants for the two-stage watchdog
package sgwd_pkg;

  typedef logic [1:0]  op_t;
  typedef logic [11:0] reg_ofs_t;
  typedef logic [31:0] word_t;
  typedef logic [63:0] count_t;

  // operation codes
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_WRITE = 2'd2;

  // frame select codes
  localparam logic FRAME_CONTROL = 1'b0;
  localparam logic FRAME_REFRESH = 1'b1;

  // control frame register offsets
  localparam reg_ofs_t OFS_CONTROL = 12'h000;
  localparam reg_ofs_t OFS_OFFSET  = 12'h008;
  localparam reg_ofs_t OFS_CMP_LO  = 12'h010;
  localparam reg_ofs_t OFS_CMP_HI  = 12'h014;
  // refresh frame register offset
  localparam reg_ofs_t OFS_REFRESH = 12'h000;

  // control/status bit positions
  localparam int CTL_EN_BIT  = 0;
  localparam int CTL_WS0_BIT = 1;
  localparam int CTL_WS1_BIT = 2;

  typedef struct packed {
    op_t      operation;
    logic     frame_select;
    reg_ofs_t register_offset;
    word_t    write_data;
    count_t   system_count;
  } sgwd_item_t;

  typedef struct packed {
    word_t read_data;
    logic  stage_one_signal;
    logic  stage_two_signal;
  } sgwd_result_t;

endpackage

// ===== rtl/sgwd_if.sv =====
// valid/ready channel interfaces for watchdog transactions and results
interface sgwd_in_if import sgwd_pkg::*; ();
  logic     valid;
  logic     ready;
  op_t      operation;
  logic     frame_select;
  reg_ofs_t register_offset;
  word_t    write_data;
  count_t   system_count;

  modport source (
    output valid, operation, frame_select, register_offset, write_data, system_count,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_select, register_offset, write_data, system_count,
    output ready
  );
endinterface

interface sgwd_out_if import sgwd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t read_data;
  logic  stage_one_signal;
  logic  stage_two_signal;

  modport source (
    output valid, read_data, stage_one_signal, stage_two_signal,
    input  ready
  );
  modport sink (
    input  valid, read_data, stage_one_signal, stage_two_signal,
    output ready
  );
endinterface

// ===== rtl/sgwd_core.sv =====
// watchdog register file, refresh and expiry logic
module sgwd_core import sgwd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  sgwd_item_t   item,
  output sgwd_result_t result
);

  logic   enabled_r, enabled_nxt;
  logic   first_r, first_nxt;
  logic   second_r, second_nxt;
  word_t  offset_r, offset_nxt;
  count_t compare_r, compare_nxt;

  count_t reload;
  logic   expired;
  word_t  rd;

  assign reload  = item.system_count + {32'd0, offset_r};
  assign expired = item.system_count > compare_r;

  always_comb begin
    enabled_nxt = enabled_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    offset_nxt  = offset_r;
    compare_nxt = compare_r;
    rd          = '0;
    case (item.operation)
      OP_TICK: begin
        if (enabled_r && expired) begin
          if (!first_r) begin
            first_nxt   = 1'b1;
            compare_nxt = reload;
          end else if (!second_r) begin
            second_nxt = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (item.frame_select == FRAME_CONTROL) begin
          case (item.register_offset)
            OFS_CONTROL: begin
              rd[CTL_EN_BIT]  = enabled_r;
              rd[CTL_WS0_BIT] = first_r;
              rd[CTL_WS1_BIT] = second_r;
            end
            OFS_OFFSET: rd = offset_r;
            OFS_CMP_LO: rd = compare_r[31:0];
            OFS_CMP_HI: rd = compare_r[63:32];
            default:    rd = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (item.frame_select == FRAME_REFRESH) begin
          if (item.register_offset == OFS_REFRESH) begin
            compare_nxt = reload;
            first_nxt   = 1'b0;
            second_nxt  = 1'b0;
          end
        end else begin
          case (item.register_offset)
            OFS_CONTROL: begin
              enabled_nxt = item.write_data[CTL_EN_BIT];
              compare_nxt = reload;
              first_nxt   = 1'b0;
              second_nxt  = 1'b0;
            end
            OFS_OFFSET: begin
              // refresh uses the newly written offset
              offset_nxt  = item.write_data;
              compare_nxt = item.system_count + {32'd0, item.write_data};
              first_nxt   = 1'b0;
              second_nxt  = 1'b0;
            end
            OFS_CMP_LO: compare_nxt = {compare_r[63:32], item.write_data};
            OFS_CMP_HI: compare_nxt = {item.write_data, compare_r[31:0]};
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      first_r   <= 1'b0;
      second_r  <= 1'b0;
      offset_r  <= '0;
      compare_r <= '0;
    end else if (fire) begin
      enabled_r <= enabled_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      offset_r  <= offset_nxt;
      compare_r <= compare_nxt;
    end
  end

  assign result.read_data        = rd;
  assign result.stage_one_signal = first_nxt;
  assign result.stage_two_signal = second_nxt;

endmodule

// ===== rtl/two_stage_watchdog_top.sv =====
// two-stage watchdog top level: input register, core and result register
// a transaction accepted into the input register passes through the core into the result register
// throughput: one transaction per cycle unless out_if.ready holds the result register
// the input register frees up whenever the result register moves, so both stages stream
// reset (rst_n low, synchronous): pipeline emptied, watchdog disabled,
// offset and compare values zero, both stage flags cleared
module two_stage_watchdog_top import sgwd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sgwd_in_if.sink   in_if,
  sgwd_out_if.source out_if
);

  // input register holds one accepted transaction
  logic       in_v_r, in_v_nxt;
  sgwd_item_t in_item_r;

  // result register holds one finished result
  logic         out_v_r, out_v_nxt;
  sgwd_result_t out_res_r;

  sgwd_result_t core_res;
  logic         adv;      // input register moves into the result register
  logic         in_fire;  // new transaction accepted

  // move forward whenever the result slot is empty or being drained
  assign adv     = in_v_r && (!out_v_r || out_if.ready);
  assign in_fire = in_if.valid && in_if.ready;

  // take a new transaction when the input register is empty or the held one moves on
  assign in_if.ready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.operation       <= in_if.operation;
      in_item_r.frame_select    <= in_if.frame_select;
      in_item_r.register_offset <= in_if.register_offset;
      in_item_r.write_data      <= in_if.write_data;
      in_item_r.system_count    <= in_if.system_count;
    end
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  // state updates only when the transaction leaves the input register
  sgwd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (in_item_r),
    .result (core_res)
  );

  assign out_if.valid            = out_v_r;
  assign out_if.read_data        = out_res_r.read_data;
  assign out_if.stage_one_signal = out_res_r.stage_one_signal;
  assign out_if.stage_two_signal = out_res_r.stage_two_signal;

`ifndef SYNTH
  // the stage two flag only ever follows the stage one flag
  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!out_res_r.stage_two_signal || out_res_r.stage_one_signal))
    else $error("stage two flag without stage one flag");

  // a full pipeline under back-pressure must not take another transaction
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while both stages are stalled");

  // a result only appears after a transaction sat in the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(in_v_r))
    else $error("result produced without a held transaction");
`endif

endmodule

// ===== test/two_stage_watchdog_top_test.sv =====
// self-checking testbench for the two-stage watchdog top level
`timescale 1ns / 100ps

module two_stage_watchdog_top_test;
  import sgwd_pkg::*;

  // operation code the block must ignore (not in the package map)
  localparam op_t OP_IGNORED = 2'd3;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_OFF_CYCLES = 200;

  // one row of the directed plan: a transaction plus an optional typed-in answer
  typedef struct {
    sgwd_item_t   txn;
    bit           typed;
    sgwd_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  sgwd_in_if  in_ch ();
  sgwd_out_if out_ch ();

  two_stage_watchdog_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // 10 ns clock, first rising edge at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog state as the testbench sees it
  logic   wd_enabled;
  logic   wd_ws0;
  logic   wd_ws1;
  word_t  wd_offset;
  count_t wd_compare;

  sgwd_result_t predicted_status_q[$];
  plan_row_t    plan[$];

  int error_count   = 0;
  int rx_count      = 0;
  int tx_burst_left = 0;
  int rx_burst_left = 0;

  // explicit refresh: new deadline from the current count, both stages cleared
  function automatic void wd_refresh(input count_t now);
    wd_compare = now + {32'd0, wd_offset};
    wd_ws0     = 1'b0;
    wd_ws1     = 1'b0;
  endfunction

  // advance the watchdog state by one transaction and return its status word
  function automatic sgwd_result_t predict_watchdog(input sgwd_item_t txn);
    sgwd_result_t res;
    word_t        rd;
    rd = '0;
    case (txn.operation)
      OP_TICK: begin
        // only ticks evaluate expiry; once both stages are set nothing moves
        if (wd_enabled && txn.system_count > wd_compare) begin
          if (!wd_ws0) begin
            wd_ws0     = 1'b1;
            wd_compare = txn.system_count + {32'd0, wd_offset};
          end else if (!wd_ws1) begin
            wd_ws1 = 1'b1;
          end
        end
      end
      OP_READ: begin
        // the refresh frame reads zero everywhere
        if (txn.frame_select == FRAME_CONTROL) begin
          case (txn.register_offset)
            OFS_CONTROL: begin
              rd[CTL_EN_BIT]  = wd_enabled;
              rd[CTL_WS0_BIT] = wd_ws0;
              rd[CTL_WS1_BIT] = wd_ws1;
            end
            OFS_OFFSET: rd = wd_offset;
            OFS_CMP_LO: rd = wd_compare[31:0];
            OFS_CMP_HI: rd = wd_compare[63:32];
            default:    rd = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (txn.frame_select == FRAME_REFRESH) begin
          if (txn.register_offset == OFS_REFRESH) wd_refresh(txn.system_count);
        end else begin
          case (txn.register_offset)
            OFS_CONTROL: begin
              // only the enable bit is writable, and the write refreshes
              wd_enabled = txn.write_data[CTL_EN_BIT];
              wd_refresh(txn.system_count);
            end
            OFS_OFFSET: begin
              wd_offset = txn.write_data;
              wd_refresh(txn.system_count);
            end
            // half writes are no refresh and keep the flags
            OFS_CMP_LO: wd_compare[31:0]  = txn.write_data;
            OFS_CMP_HI: wd_compare[63:32] = txn.write_data;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res.read_data        = rd;
    res.stage_one_signal = wd_ws0;
    res.stage_two_signal = wd_ws1;
    return res;
  endfunction

  function automatic void plan_row(input op_t op, input logic frame, input reg_ofs_t ofs,
                                   input word_t data, input count_t cnt, input bit typed,
                                   input word_t rd, input logic s1, input logic s2);
    plan_row_t row;
    row.txn.operation             = op;
    row.txn.frame_select          = frame;
    row.txn.register_offset       = ofs;
    row.txn.write_data            = data;
    row.txn.system_count          = cnt;
    row.typed                     = typed;
    row.want.read_data            = rd;
    row.want.stage_one_signal     = s1;
    row.want.stage_two_signal     = s2;
    plan.push_back(row);
  endfunction

  // offer one transaction after a random gap, then log what it should produce
  task automatic offer_item(input sgwd_item_t txn, input bit typed,
                            input sgwd_result_t want);
    int           gap;
    sgwd_result_t guess;
    if (tx_burst_left > 0) begin
      gap = 0;
      tx_burst_left--;
    end else begin
      gap = $urandom_range(0, 14);
      // now and then a back-to-back stretch
      if ($urandom_range(0, 39) == 0) tx_burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= txn.operation;
    in_ch.frame_select    <= txn.frame_select;
    in_ch.register_offset <= txn.register_offset;
    in_ch.write_data      <= txn.write_data;
    in_ch.system_count    <= txn.system_count;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // accepted at this edge: predictor runs in acceptance order
    guess = predict_watchdog(txn);
    predicted_status_q.push_back(typed ? want : guess);
  endtask

  // result side: random stalls, bursts, and a couple of long hold-offs
  initial begin
    int           stall;
    sgwd_result_t exp_res;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_count == 150 || rx_count == 600) begin
        // long hold-off: the pipeline fills and the input side stalls
        stall = HOLD_OFF_CYCLES;
      end else if (rx_burst_left > 0) begin
        stall = 0;
        rx_burst_left--;
      end else begin
        stall = $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0) rx_burst_left = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      rx_count++;
      if (predicted_status_q.size() == 0) begin
        $error("result transaction with nothing pending: read_data %h", out_ch.read_data);
        error_count++;
      end else begin
        exp_res = predicted_status_q.pop_front();
        if (out_ch.read_data !== exp_res.read_data) begin
          $error("read_data expected %h actual %h", exp_res.read_data, out_ch.read_data);
          error_count++;
        end
        if (out_ch.stage_one_signal !== exp_res.stage_one_signal) begin
          $error("stage_one_signal expected %b actual %b",
                 exp_res.stage_one_signal, out_ch.stage_one_signal);
          error_count++;
        end
        if (out_ch.stage_two_signal !== exp_res.stage_two_signal) begin
          $error("stage_two_signal expected %b actual %b",
                 exp_res.stage_two_signal, out_ch.stage_two_signal);
          error_count++;
        end
      end
    end
  end

  // stimulus, drain and verdict
  initial begin
    sgwd_item_t   txn;
    sgwd_result_t none;
    count_t       sys_now;
    int           pick;

    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_TICK;
    in_ch.frame_select    = FRAME_CONTROL;
    in_ch.register_offset = '0;
    in_ch.write_data      = '0;
    in_ch.system_count    = '0;
    rst_n                 = 1'b0;
    none                  = '0;

    wd_enabled = 1'b0;
    wd_ws0     = 1'b0;
    wd_ws1     = 1'b0;
    wd_offset  = '0;
    wd_compare = '0;

    // directed plan: reset values, wrap of the deadline, both expiry stages,
    // read-only flag bits, half writes, refresh frame, unmapped and ignored codes
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h0, 1, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_OFFSET,  32'h0, 64'h0, 1, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CMP_LO,  32'h0, 64'h0, 1, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CMP_HI,  32'h0, 64'h0, 1, 32'h0, 0, 0);
    // tick while disabled, even with the count at its top
    plan_row(OP_TICK,  FRAME_CONTROL, OFS_CONTROL, 32'h0, '1, 1, 32'h0, 0, 0);
    // max offset at max count: the deadline wraps to 0x0000_0000_ffff_fffe
    plan_row(OP_WRITE, FRAME_CONTROL, OFS_OFFSET, '1, '1, 1, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CMP_LO, 32'h0, 64'h0, 1, 32'hffff_fffe, 0, 0);
    // all ones to control: only enable sticks, deadline becomes 0xffff_ffff
    plan_row(OP_WRITE, FRAME_CONTROL, OFS_CONTROL, '1, 64'h0, 1, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h0, 1, 32'h1, 0, 0);
    // count equal to the deadline is no expiry
    plan_row(OP_TICK,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'hffff_ffff, 1, 32'h0, 0, 0);
    // first stage, then second stage, then nothing more
    plan_row(OP_TICK,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h1_0000_0000, 1, 32'h0, 1, 0);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h0, 1, 32'h3, 1, 0);
    plan_row(OP_TICK,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h2_0000_0000, 1, 32'h0, 1, 1);
    plan_row(OP_TICK,  FRAME_CONTROL, OFS_CONTROL, 32'h0, '1, 1, 32'h0, 1, 1);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CONTROL, 32'h0, 64'h0, 1, 32'h7, 1, 1);
    // half writes keep the flags
    plan_row(OP_WRITE, FRAME_CONTROL, OFS_CMP_HI, '1, 64'h0, 1, 32'h0, 1, 1);
    plan_row(OP_WRITE, FRAME_CONTROL, OFS_CMP_LO, 32'h1234_5678, 64'h0, 1, 32'h0, 1, 1);
    plan_row(OP_READ,  FRAME_CONTROL, OFS_CMP_HI, 32'h0, 64'h0, 1, 32'hffff_ffff, 1, 1);
    // refresh frame reads zero; writes off the refresh offset are ignored
    plan_row(OP_READ,  FRAME_REFRESH, OFS_REFRESH, 32'h0, 64'h0, 1, 32'h0, 1, 1);
    plan_row(OP_WRITE, FRAME_REFRESH, 12'h004, '1, 64'h0, 1, 32'h0, 1, 1);
    plan_row(OP_WRITE, FRAME_REFRESH, OFS_REFRESH, 32'h0, 64'h5, 1, 32'h0, 0, 0);
    // unaligned, identity and unmapped offsets go through the predictor
    plan_row(OP_READ,  FRAME_CONTROL, 12'h00c, 32'h0, 64'h0, 0, 32'h0, 0, 0);
    plan_row(OP_READ,  FRAME_CONTROL, 12'hfcc, 32'h0, 64'h0, 0, 32'h0, 0, 0);
    plan_row(OP_WRITE, FRAME_CONTROL, '1, 32'hdead_beef, 64'h0, 0, 32'h0, 0, 0);
    plan_row(OP_IGNORED, FRAME_REFRESH, '1, '1, '1, 1, 32'h0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer_item(plan[i].txn, plan[i].typed, plan[i].want);

    // random part: a free-running count with small offsets so both stages
    // fire often, refreshes to restart, and some fully random noise
    sys_now = {$urandom(), $urandom()} >> $urandom_range(0, 63);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick    = $urandom_range(0, 99);
      sys_now = sys_now + $urandom_range(0, 12);
      if ($urandom_range(0, 99) == 0) sys_now = {$urandom(), $urandom()};
      if ($urandom_range(0, 199) == 0) sys_now = '1 - $urandom_range(0, 30);

      txn.operation       = OP_TICK;
      txn.frame_select    = FRAME_CONTROL;
      txn.register_offset = reg_ofs_t'($urandom());
      txn.write_data      = $urandom();
      txn.system_count    = sys_now;

      if (pick < 45) begin
        // plain tick, leftover fields random
      end else if (pick < 62) begin
        txn.operation    = OP_READ;
        txn.frame_select = ($urandom_range(0, 9) == 0) ? FRAME_REFRESH : FRAME_CONTROL;
        case ($urandom_range(0, 3))
          0:       txn.register_offset = OFS_CONTROL;
          1:       txn.register_offset = OFS_OFFSET;
          2:       txn.register_offset = OFS_CMP_LO;
          default: txn.register_offset = OFS_CMP_HI;
        endcase
      end else if (pick < 70) begin
        txn.operation       = OP_WRITE;
        txn.frame_select    = FRAME_REFRESH;
        txn.register_offset = OFS_REFRESH;
      end else if (pick < 76) begin
        // mostly enabling writes so the watchdog stays live
        txn.operation                  = OP_WRITE;
        txn.register_offset            = OFS_CONTROL;
        txn.write_data[CTL_EN_BIT]     = ($urandom_range(0, 9) != 0);
      end else if (pick < 82) begin
        txn.operation       = OP_WRITE;
        txn.register_offset = OFS_OFFSET;
        if ($urandom_range(0, 7) != 0) txn.write_data = $urandom_range(0, 40);
      end else if (pick < 88) begin
        txn.operation = OP_WRITE;
        if ($urandom_range(0, 1) == 0) begin
          txn.register_offset = OFS_CMP_LO;
        end else begin
          txn.register_offset = OFS_CMP_HI;
          if ($urandom_range(0, 3) != 0) txn.write_data = sys_now[63:32];
        end
      end else begin
        // noise: any operation, frame, offset and count
        txn.operation    = op_t'($urandom_range(0, 3));
        txn.frame_select = 1'($urandom_range(0, 1));
        txn.system_count = {$urandom(), $urandom()};
      end
      offer_item(txn, 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    // wait for every pending result, then keep watching for strays
    while (predicted_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("two_stage_watchdog_top_test: PASS");
    end else begin
      $display("two_stage_watchdog_top_test: FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("two_stage_watchdog_top_test: FAIL");
    $finish;
  end

endmodule

// ===== two_stage_watchdog_top.f =====
rtl/sgwd_pkg.sv
rtl/sgwd_if.sv
rtl/sgwd_core.sv
rtl/two_stage_watchdog_top.sv
test/two_stage_watchdog_top_test.sv
